[rtl/assert_macros.svh]
// assert_macros.svh - concurrent assertion helpers for the PM2.5 AQI averager.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/pm25aqi_pkg.sv]
// pm25aqi_pkg - widths, breakpoint tables and shared types of the PM2.5 AQI averager.
// No dependencies.
package pm25aqi_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CONC_W     = 10;
    localparam int AQI_W      = 14;
    localparam int CAT_W      = 3;
    localparam int SEG_W      = 3;
    localparam int NUM_W      = 24;
    localparam int ILO_W      = 13;
    localparam int SPAN_W     = 11;
    localparam int CLO_W      = 12;
    localparam int TENTHS_W   = 14;
    localparam int OUT_CNT_W  = 16;

    // segment division as num * ceil(2^35 / den) >> 35, exact for num below 2^24
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 35;

    localparam int SUM_C_W = CONC_W + COUNT_BITS;
    localparam int SUM_A_W = AQI_W + COUNT_BITS;

    // serial divider: quotient always fits in QB bits
    localparam int QB    = 14;
    localparam int DIV_N = SUM_A_W;
    localparam int DIV_D = COUNT_BITS;

    localparam int Q_DEPTH = 2;

    localparam logic [CONC_W-1:0]     CONC_MAX   = CONC_W'(1000);
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    localparam logic [CAT_W-1:0] CAT_GOOD      = 3'd0;
    localparam logic [CAT_W-1:0] CAT_MODERATE  = 3'd1;
    localparam logic [CAT_W-1:0] CAT_SENSITIVE = 3'd2;
    localparam logic [CAT_W-1:0] CAT_UNHEALTHY = 3'd3;
    localparam logic [CAT_W-1:0] CAT_VERY      = 3'd4;
    localparam logic [CAT_W-1:0] CAT_HAZARDOUS = 3'd5;

    typedef struct packed {
        logic [CONC_W-1:0]  pm1;
        logic [CONC_W-1:0]  pm2_5;
        logic [CONC_W-1:0]  pm10;
        logic               restart;
        logic [NUM_W-1:0]   num;
        logic [RECIP_W-1:0] recip;
        logic [ILO_W-1:0]   ilo16;
        logic [CAT_W-1:0]   cat;
    } t_item;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    function automatic logic [CONC_W-1:0] clamp_conc(input logic [CONC_W-1:0] v);
        return (v > CONC_MAX) ? CONC_MAX : v;
    endfunction

    function automatic logic [SEG_W-1:0] seg_pick(input logic [CONC_W-1:0] c);
        logic [SEG_W-1:0] s;
        if (c <= CONC_W'(12))       s = 3'd0;
        else if (c <= CONC_W'(35))  s = 3'd1;
        else if (c <= CONC_W'(55))  s = 3'd2;
        else if (c <= CONC_W'(150)) s = 3'd3;
        else if (c <= CONC_W'(250)) s = 3'd4;
        else if (c <= CONC_W'(350)) s = 3'd5;
        else                        s = 3'd6;
        return s;
    endfunction

    // 16 * (iHi - iLo)
    function automatic logic [SPAN_W-1:0] seg_span16(input logic [SEG_W-1:0] s);
        logic [SPAN_W-1:0] v;
        case (s)
            3'd0:    v = SPAN_W'(800);
            3'd1:    v = SPAN_W'(784);
            3'd2:    v = SPAN_W'(784);
            3'd3:    v = SPAN_W'(784);
            default: v = SPAN_W'(1584);
        endcase
        return v;
    endfunction

    // lower concentration bound, tenths of ug/m3
    function automatic logic [CLO_W-1:0] seg_clo(input logic [SEG_W-1:0] s);
        logic [CLO_W-1:0] v;
        case (s)
            3'd0:    v = CLO_W'(0);
            3'd1:    v = CLO_W'(121);
            3'd2:    v = CLO_W'(355);
            3'd3:    v = CLO_W'(555);
            3'd4:    v = CLO_W'(1505);
            3'd5:    v = CLO_W'(2505);
            default: v = CLO_W'(3505);
        endcase
        return v;
    endfunction

    // ceil(2^35 / (cHi - cLo)) for spans 120, 233, 199, 949, 999, 999, 1499
    function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] s);
        logic [RECIP_W-1:0] v;
        case (s)
            3'd0:    v = RECIP_W'(286331154);
            3'd1:    v = RECIP_W'(147466689);
            3'd2:    v = RECIP_W'(172662002);
            3'd3:    v = RECIP_W'(36206258);
            3'd4:    v = RECIP_W'(34394133);
            3'd5:    v = RECIP_W'(34394133);
            default: v = RECIP_W'(22921774);
        endcase
        return v;
    endfunction

    function automatic logic [ILO_W-1:0] seg_ilo16(input logic [SEG_W-1:0] s);
        logic [ILO_W-1:0] v;
        case (s)
            3'd0:    v = ILO_W'(0);
            3'd1:    v = ILO_W'(816);
            3'd2:    v = ILO_W'(1616);
            3'd3:    v = ILO_W'(2416);
            3'd4:    v = ILO_W'(3216);
            3'd5:    v = ILO_W'(4816);
            default: v = ILO_W'(6416);
        endcase
        return v;
    endfunction

    // both top segments report hazardous
    function automatic logic [CAT_W-1:0] seg_cat(input logic [SEG_W-1:0] s);
        logic [CAT_W-1:0] v;
        case (s)
            3'd0:    v = CAT_GOOD;
            3'd1:    v = CAT_MODERATE;
            3'd2:    v = CAT_SENSITIVE;
            3'd3:    v = CAT_UNHEALTHY;
            3'd4:    v = CAT_VERY;
            default: v = CAT_HAZARDOUS;
        endcase
        return v;
    endfunction

endpackage

[rtl/pm25aqi_front.sv]
// pm25aqi_front - takes samples, clamps them, picks the AQI segment and forms the
// interpolation numerator. Depends on pm25aqi_pkg.
module pm25aqi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pm25aqi_pkg::CONC_W-1:0] i_pm1_conc,
    input  logic [pm25aqi_pkg::CONC_W-1:0] i_pm2_5_conc,
    input  logic [pm25aqi_pkg::CONC_W-1:0] i_pm10_conc,
    input  logic                          i_restart,
    input  pm25aqi_pkg::t_q_stat          i_q_stat,
    output logic                          o_push,
    output pm25aqi_pkg::t_item            o_item
);

    logic                           r_valid;
    logic [pm25aqi_pkg::CONC_W-1:0] r_pm1;
    logic [pm25aqi_pkg::CONC_W-1:0] r_pm2_5;
    logic [pm25aqi_pkg::CONC_W-1:0] r_pm10;
    logic                           r_restart;
    logic [pm25aqi_pkg::SEG_W-1:0]  r_seg;

    logic [pm25aqi_pkg::TENTHS_W-1:0]            tenths;
    logic [pm25aqi_pkg::TENTHS_W-1:0]            offs;
    logic [pm25aqi_pkg::SPAN_W+pm25aqi_pkg::TENTHS_W-1:0] prod;

    assign o_push  = r_valid && !i_q_stat.full;
    assign o_ready = !r_valid || o_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pm1     <= pm25aqi_pkg::clamp_conc(i_pm1_conc);
            r_pm2_5   <= pm25aqi_pkg::clamp_conc(i_pm2_5_conc);
            r_pm10    <= pm25aqi_pkg::clamp_conc(i_pm10_conc);
            r_restart <= i_restart;
            r_seg     <= pm25aqi_pkg::seg_pick(pm25aqi_pkg::clamp_conc(i_pm2_5_conc));
        end
    end

    // 10*C - cLo never goes negative inside the chosen segment
    always_comb begin
        tenths = {1'b0, r_pm2_5, 3'b000} + {3'b000, r_pm2_5, 1'b0};
        offs   = tenths - pm25aqi_pkg::TENTHS_W'(pm25aqi_pkg::seg_clo(r_seg));
        prod   = {{pm25aqi_pkg::TENTHS_W{1'b0}}, pm25aqi_pkg::seg_span16(r_seg)}
               * {{pm25aqi_pkg::SPAN_W{1'b0}}, offs};
    end

    always_comb begin
        o_item.pm1     = r_pm1;
        o_item.pm2_5   = r_pm2_5;
        o_item.pm10    = r_pm10;
        o_item.restart = r_restart;
        o_item.num     = prod[pm25aqi_pkg::NUM_W-1:0];
        o_item.recip   = pm25aqi_pkg::seg_recip(r_seg);
        o_item.ilo16   = pm25aqi_pkg::seg_ilo16(r_seg);
        o_item.cat     = pm25aqi_pkg::seg_cat(r_seg);
    end

endmodule

[rtl/pm25aqi_fifo.sv]
// pm25aqi_fifo - short queue of classified samples between front and back.
// Depends on pm25aqi_pkg.
module pm25aqi_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pm25aqi_pkg::t_item   i_item,
    input  logic                 i_pop,
    output pm25aqi_pkg::t_item   o_item,
    output pm25aqi_pkg::t_q_stat o_stat
);

    localparam int PW = (pm25aqi_pkg::Q_DEPTH > 1) ? $clog2(pm25aqi_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(pm25aqi_pkg::Q_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(pm25aqi_pkg::Q_DEPTH - 1);

    pm25aqi_pkg::t_item r_mem [pm25aqi_pkg::Q_DEPTH];
    logic [PW-1:0]      r_wr;
    logic [PW-1:0]      r_rd;
    logic [CW-1:0]      r_cnt;

    assign o_stat.full      = (r_cnt == CW'(pm25aqi_pkg::Q_DEPTH));
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_item           = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[rtl/pm25aqi_div.sv]
// pm25aqi_div - restoring divider, one quotient bit per cycle, for quotients that
// fit in QB bits. Depends on pm25aqi_pkg.
module pm25aqi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pm25aqi_pkg::DIV_N-1:0] i_dividend,
    input  logic [pm25aqi_pkg::DIV_D-1:0] i_divisor,
    output logic                          o_done,
    output logic [pm25aqi_pkg::QB-1:0]    o_quot
);

    localparam int D  = pm25aqi_pkg::DIV_D;
    localparam int QB = pm25aqi_pkg::QB;
    localparam int CW = $clog2(QB + 1);

    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_dvs;
    logic [QB-1:0] r_low;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          ge;

    // remainder and dividend bits shift together; quotient bits fill in from the right
    always_comb begin
        trial = {r_rem, r_low[QB-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    assign o_done = r_done;
    assign o_quot = r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper part is below the divisor since the quotient fits in QB bits
            r_rem <= D'(i_dividend[pm25aqi_pkg::DIV_N-1:QB]);
            r_low <= i_dividend[QB-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[D-1:0] : trial[D-1:0];
            r_low <= {r_low[QB-2:0], ge};
        end
    end

endmodule

[rtl/pm25aqi_back.sv]
// pm25aqi_back - finishes the AQI by reciprocal multiply, keeps the running sums and
// count, and forms the four averages on one shared divider. Depends on pm25aqi_pkg, pm25aqi_div.
module pm25aqi_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pm25aqi_pkg::t_q_stat              i_q_stat,
    input  pm25aqi_pkg::t_item                i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pm25aqi_pkg::AQI_W-1:0]     o_sample_aqi,
    output logic [pm25aqi_pkg::CAT_W-1:0]     o_category,
    output logic [pm25aqi_pkg::CONC_W-1:0]    o_avg_pm1,
    output logic [pm25aqi_pkg::CONC_W-1:0]    o_avg_pm2_5,
    output logic [pm25aqi_pkg::CONC_W-1:0]    o_avg_pm10,
    output logic [pm25aqi_pkg::AQI_W-1:0]     o_avg_aqi,
    output logic [pm25aqi_pkg::OUT_CNT_W-1:0] o_sample_count
);

    localparam int CONC_W = pm25aqi_pkg::CONC_W;
    localparam int AQI_W  = pm25aqi_pkg::AQI_W;
    localparam int CB     = pm25aqi_pkg::COUNT_BITS;
    localparam int PROD_W = pm25aqi_pkg::NUM_W + pm25aqi_pkg::RECIP_W;
    localparam int QLO    = pm25aqi_pkg::RECIP_SHIFT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AQI  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_AVG  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [1:0] AVG_PM1   = 2'd0;
    localparam logic [1:0] AVG_PM2_5 = 2'd1;
    localparam logic [1:0] AVG_PM10  = 2'd2;
    localparam logic [1:0] AVG_AQI   = 2'd3;

    logic [2:0]                        r_state;
    logic                              r_go;
    logic [1:0]                        r_idx;
    pm25aqi_pkg::t_item                r_item;
    logic [AQI_W-1:0]                  r_aqi;
    logic [pm25aqi_pkg::SUM_C_W-1:0]   r_sum_pm1;
    logic [pm25aqi_pkg::SUM_C_W-1:0]   r_sum_pm2_5;
    logic [pm25aqi_pkg::SUM_C_W-1:0]   r_sum_pm10;
    logic [pm25aqi_pkg::SUM_A_W-1:0]   r_sum_aqi;
    logic [CB-1:0]                     r_count;
    logic [CONC_W-1:0]                 r_avg_pm1;
    logic [CONC_W-1:0]                 r_avg_pm2_5;
    logic [CONC_W-1:0]                 r_avg_pm10;
    logic [AQI_W-1:0]                  r_avg_aqi;
    logic                              r_out_valid;

    logic [pm25aqi_pkg::DIV_N-1:0]     dividend;
    logic [pm25aqi_pkg::DIV_D-1:0]     divisor;
    logic                              div_done;
    logic [pm25aqi_pkg::QB-1:0]        quot;
    logic                              load_out;
    logic [PROD_W-1:0]                 aqi_prod;

    assign o_pop    = (r_state == S_IDLE) && i_q_stat.not_empty;
    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;

    // quotient of the segment division sits at bit 35 and up; it is below 2^14
    assign aqi_prod = {{pm25aqi_pkg::RECIP_W{1'b0}}, r_item.num}
                    * {{pm25aqi_pkg::NUM_W{1'b0}}, r_item.recip};

    assign divisor = pm25aqi_pkg::DIV_D'(r_count);

    always_comb begin
        case (r_idx)
            AVG_PM1:   dividend = pm25aqi_pkg::DIV_N'(r_sum_pm1);
            AVG_PM2_5: dividend = pm25aqi_pkg::DIV_N'(r_sum_pm2_5);
            AVG_PM10:  dividend = pm25aqi_pkg::DIV_N'(r_sum_pm10);
            default:   dividend = pm25aqi_pkg::DIV_N'(r_sum_aqi);
        endcase
    end

    pm25aqi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_idx       <= AVG_PM1;
            r_out_valid <= 1'b0;
            r_sum_pm1   <= '0;
            r_sum_pm2_5 <= '0;
            r_sum_pm10  <= '0;
            r_sum_aqi   <= '0;
            r_count     <= '0;
        end else begin
            r_go <= 1'b0;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_AQI;
                    end
                end
                S_AQI: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    // restart opens a new window; a full window keeps its sums
                    if (r_item.restart) begin
                        r_sum_pm1   <= pm25aqi_pkg::SUM_C_W'(r_item.pm1);
                        r_sum_pm2_5 <= pm25aqi_pkg::SUM_C_W'(r_item.pm2_5);
                        r_sum_pm10  <= pm25aqi_pkg::SUM_C_W'(r_item.pm10);
                        r_sum_aqi   <= pm25aqi_pkg::SUM_A_W'(r_aqi);
                        r_count     <= CB'(1);
                    end else if (r_count != pm25aqi_pkg::COUNT_FULL) begin
                        r_sum_pm1   <= r_sum_pm1 + pm25aqi_pkg::SUM_C_W'(r_item.pm1);
                        r_sum_pm2_5 <= r_sum_pm2_5 + pm25aqi_pkg::SUM_C_W'(r_item.pm2_5);
                        r_sum_pm10  <= r_sum_pm10 + pm25aqi_pkg::SUM_C_W'(r_item.pm10);
                        r_sum_aqi   <= r_sum_aqi + pm25aqi_pkg::SUM_A_W'(r_aqi);
                        r_count     <= r_count + 1'b1;
                    end
                    r_idx   <= AVG_PM1;
                    r_go    <= 1'b1;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    if (div_done) begin
                        if (r_idx == AVG_AQI) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_go  <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_AQI) begin
            r_aqi <= aqi_prod[QLO+AQI_W-1:QLO] + AQI_W'(r_item.ilo16);
        end
        if (r_state == S_AVG && div_done) begin
            case (r_idx)
                AVG_PM1:   r_avg_pm1   <= quot[CONC_W-1:0];
                AVG_PM2_5: r_avg_pm2_5 <= quot[CONC_W-1:0];
                AVG_PM10:  r_avg_pm10  <= quot[CONC_W-1:0];
                default:   r_avg_aqi   <= quot[AQI_W-1:0];
            endcase
        end
        if (load_out) begin
            o_sample_aqi   <= r_aqi;
            o_category     <= r_item.cat;
            o_avg_pm1      <= r_avg_pm1;
            o_avg_pm2_5    <= r_avg_pm2_5;
            o_avg_pm10     <= r_avg_pm10;
            o_avg_aqi      <= r_avg_aqi;
            o_sample_count <= pm25aqi_pkg::OUT_CNT_W'(r_count);
        end
    end

endmodule

[rtl/pm25_aqi_averager_core.sv]
// pm25_aqi_averager_core - top level of the PM2.5 AQI averager: front, queue, back.
// Depends on pm25aqi_pkg, pm25aqi_front, pm25aqi_fifo, pm25aqi_back, assert_macros.svh.
//
//   channel   direction  handshake           payload
//   sample    in         i_valid / o_ready   i_pm1_conc i_pm2_5_conc i_pm10_conc i_restart
//   result    out        o_valid / i_ready   o_sample_aqi o_category o_avg_* o_sample_count
//
// The front takes a sample in any cycle it has room; a two-entry queue follows it.
// The back takes one sample at a time: S_AQI for the AQI reciprocal multiply, S_UPD for the
// sums, four runs of the shared 14-step divider in S_AVG, S_OUT to load the output register.
// Synchronous active-low reset clears the sums, the count and all valid flags.
// A stalled result holds in the output register; the back finishes the next one and waits.
`include "assert_macros.svh"
module pm25_aqi_averager_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pm25aqi_pkg::CONC_W-1:0]    i_pm1_conc,
    input  logic [pm25aqi_pkg::CONC_W-1:0]    i_pm2_5_conc,
    input  logic [pm25aqi_pkg::CONC_W-1:0]    i_pm10_conc,
    input  logic                              i_restart,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pm25aqi_pkg::AQI_W-1:0]     o_sample_aqi,
    output logic [pm25aqi_pkg::CAT_W-1:0]     o_category,
    output logic [pm25aqi_pkg::CONC_W-1:0]    o_avg_pm1,
    output logic [pm25aqi_pkg::CONC_W-1:0]    o_avg_pm2_5,
    output logic [pm25aqi_pkg::CONC_W-1:0]    o_avg_pm10,
    output logic [pm25aqi_pkg::AQI_W-1:0]     o_avg_aqi,
    output logic [pm25aqi_pkg::OUT_CNT_W-1:0] o_sample_count
);

    pm25aqi_pkg::t_q_stat q_stat;
    pm25aqi_pkg::t_item   push_item;
    pm25aqi_pkg::t_item   pop_item;
    logic                 push;
    logic                 pop;

    pm25aqi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pm1_conc   (i_pm1_conc),
        .i_pm2_5_conc (i_pm2_5_conc),
        .i_pm10_conc  (i_pm10_conc),
        .i_restart    (i_restart),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_item       (push_item)
    );

    pm25aqi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (q_stat)
    );

    pm25aqi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .i_item         (pop_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_aqi   (o_sample_aqi),
        .o_category     (o_category),
        .o_avg_pm1      (o_avg_pm1),
        .o_avg_pm2_5    (o_avg_pm2_5),
        .o_avg_pm10     (o_avg_pm10),
        .o_avg_aqi      (o_avg_aqi),
        .o_sample_count (o_sample_count)
    );

    `ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, push && q_stat.full)
    `ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, pop && !q_stat.not_empty)
    `ASSERT_IMPLIES(a_cat_range, i_clk, i_rst_n, o_valid, o_category <= pm25aqi_pkg::CAT_HAZARDOUS)

endmodule
